/* rtl/mtl_pkg.sv */
`default_nettype none
package mtl_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CFG_W   = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  typedef enum logic [1:0] {
    KIND_FIND_FIRST = 2'd0,
    KIND_FIND_NEXT  = 2'd1,
    KIND_INSERT     = 2'd2,
    KIND_REUSE      = 2'd3
  } kind_e;

  typedef struct packed {
    logic             valid;
    logic             cur;
    logic [IDX_W-1:0] slot;
    logic [31:0]      pc;
    logic [31:0]      next_pc;
    logic [31:0]      serial;
    logic [31:0]      uses;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic cur_clr;
    logic cur_set;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/mtl_req_if.sv */
`default_nettype none
interface mtl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] pc;
  logic [31:0] next_pc;
  logic [5:0]  slot;

  modport source (output valid, kind, pc, next_pc, slot, input ready);
  modport sink (input valid, kind, pc, next_pc, slot, output ready);
endinterface
`default_nettype wire

/* rtl/mtl_rsp_if.sv */
`default_nettype none
interface mtl_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [5:0]  found_slot;
  logic [31:0] serial;
  logic [31:0] reuse_count;
  logic [31:0] stored_next_pc;
  logic        evicted;
  logic [31:0] evicted_pc;

  modport source (output valid, hit, found_slot, serial, reuse_count, stored_next_pc,
                  evicted, evicted_pc, input ready);
  modport sink (input valid, hit, found_slot, serial, reuse_count, stored_next_pc,
                evicted, evicted_pc, output ready);
endinterface
`default_nettype wire

/* rtl/trace_memo_table_lru.sv */
`default_nettype none
// Trace memo table with least recently used replacement.
// Requests arrive on in_i (valid/ready): kind, pc, next_pc, slot. Each item
// yields exactly one response on out_o (valid/ready): hit, found_slot, serial,
// reuse_count, stored_next_pc, evicted, evicted_pc.
// Entries live in a row of cells ordered by recency, the most recently used
// in the first cell. Promoting an entry shifts the cells ahead of it by one
// position toward the back; the moved entry enters the first cell.
// An item passes, in order, through the accept into the request register,
// S_MATCH, where every cell registers its pc and slot compare, and S_APPLY,
// which picks the winning cell, shifts the row and loads the response
// register. An item is accepted only in S_IDLE, after the last left S_APPLY.
// A response waits in the output register while out_o.ready is low; a new
// item may be accepted meanwhile, and it holds in its last cycle until the
// register frees.
// Write entries_in_use via cfg_we_i/cfg_wdata_i only while idle; not enforced.
// Reset empties the table, sets the serial counter to one, clears the search
// cursor and sets entries_in_use to 64; no clearing pass is needed.
module trace_memo_table_lru (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  mtl_req_if.sink                          in_i,
  mtl_rsp_if.source                        out_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [mtl_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int unsigned N = mtl_pkg::ENTRIES;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_e;

  state_e                       state_q;
  logic [mtl_pkg::CFG_W-1:0]    eiu_q;
  logic [mtl_pkg::CNT_W-1:0]    fill_q;
  logic [31:0]                  serial_q;
  mtl_pkg::kind_e               kind_q;
  logic [31:0]                  pc_q, npc_q;
  logic [mtl_pkg::IDX_W-1:0]    slot_q;

  logic                         ov_q;
  logic                         o_hit_q, o_evicted_q;
  logic [mtl_pkg::IDX_W-1:0]    o_slot_q;
  logic [31:0]                  o_serial_q, o_uses_q, o_npc_q, o_epc_q;

  mtl_pkg::entry_t              cells   [N];
  mtl_pkg::cell_ctl_t           ctl     [N];
  logic [N-1:0]                 match_v, slothit_v, valid_v, cur_v;
  logic [N-1:0]                 cand, sel, lower_mask, after_mask;
  mtl_pkg::entry_t              e_sel, new_e;
  logic                         hit, evict, free, apply, is_find, do_shift;
  logic [mtl_pkg::CNT_W-1:0]    limit;

  assign in_i.ready = (state_q == S_IDLE);
  assign apply      = (state_q == S_APPLY) && (!ov_q || out_o.ready);

  for (genvar k = 0; k < N; k++) begin : g_cell
    mtl_pkg::entry_t prev;
    if (k == 0) begin : g_head
      assign prev = new_e;
    end else begin : g_link
      assign prev = cells[k-1];
    end
    mtl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .prev_i     (prev),
      .ctl_i      (ctl[k]),
      .key_pc_i   (pc_q),
      .key_slot_i (slot_q),
      .entry_o    (cells[k]),
      .match_o    (match_v[k]),
      .slot_hit_o (slothit_v[k])
    );
    assign valid_v[k] = cells[k].valid;
    assign cur_v[k]   = cells[k].cur;
  end

  always_comb begin
    limit = (eiu_q > mtl_pkg::CFG_W'(N)) ? mtl_pkg::CNT_W'(N) : mtl_pkg::CNT_W'(eiu_q);
    free  = (fill_q < limit) || (fill_q == '0);
    lower_mask = cur_v | (cur_v - N'(1));
    after_mask = ~lower_mask;
    is_find = 1'b0;
    evict   = 1'b0;
    unique case (kind_q)
      mtl_pkg::KIND_FIND_FIRST: begin
        is_find = 1'b1;
        cand    = match_v;
      end
      mtl_pkg::KIND_FIND_NEXT: begin
        is_find = 1'b1;
        cand    = match_v & after_mask;
      end
      mtl_pkg::KIND_INSERT: begin
        evict = !free;
        cand  = free ? (~valid_v & {valid_v[N-2:0], 1'b1})
                     : (valid_v & ~(valid_v >> 1));
      end
      mtl_pkg::KIND_REUSE: begin
        cand = slothit_v;
      end
      default: begin
        cand = '0;
      end
    endcase
    sel = cand & (~cand + N'(1));
    hit = |sel;
    e_sel = '0;
    for (int k = 0; k < N; k++) begin
      if (sel[k]) begin
        e_sel = e_sel | cells[k];
      end
    end
    new_e = e_sel;
    if (kind_q == mtl_pkg::KIND_INSERT) begin
      new_e.valid   = 1'b1;
      new_e.cur     = evict ? e_sel.cur : 1'b0;
      new_e.slot    = evict ? e_sel.slot : fill_q[mtl_pkg::IDX_W-1:0];
      new_e.pc      = pc_q;
      new_e.next_pc = npc_q;
      new_e.serial  = serial_q;
      new_e.uses    = '0;
    end else begin
      new_e.uses = e_sel.uses + 32'd1;
    end
    do_shift = apply && !is_find && hit;
    for (int k = 0; k < N; k++) begin
      ctl[k].shift   = do_shift && (sel[k] || ((sel - N'(1)) >> k) != '0 && k < N
                       && ((sel - N'(1)) & (N'(1) << k)) != '0);
      ctl[k].cur_clr = apply && is_find;
      ctl[k].cur_set = sel[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      eiu_q       <= mtl_pkg::CFG_RESET;
      fill_q      <= '0;
      serial_q    <= 32'd1;
      ov_q        <= 1'b0;
      o_hit_q     <= 1'b0;
      o_slot_q    <= '0;
      o_serial_q  <= '0;
      o_uses_q    <= '0;
      o_npc_q     <= '0;
      o_evicted_q <= 1'b0;
      o_epc_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        eiu_q <= cfg_wdata_i;
      end
      if (apply) begin
        ov_q        <= 1'b1;
        o_hit_q     <= hit;
        o_slot_q    <= (hit && !is_find) ? new_e.slot : e_sel.slot;
        o_serial_q  <= hit ? new_e.serial : '0;
        o_uses_q    <= hit ? (is_find ? e_sel.uses : new_e.uses) : '0;
        o_npc_q     <= hit ? new_e.next_pc : '0;
        o_evicted_q <= evict;
        o_epc_q     <= evict ? e_sel.pc : '0;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            state_q <= S_MATCH;
          end
        end
        S_MATCH: begin
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          if (apply) begin
            state_q <= S_IDLE;
            if (kind_q == mtl_pkg::KIND_INSERT) begin
              serial_q <= serial_q + 32'd1;
              if (free) begin
                fill_q <= fill_q + mtl_pkg::CNT_W'(1);
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= mtl_pkg::kind_e'(in_i.kind);
      pc_q   <= in_i.pc;
      npc_q  <= in_i.next_pc;
      slot_q <= in_i.slot;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.hit            = o_hit_q;
  assign out_o.found_slot     = o_slot_q;
  assign out_o.serial         = o_serial_q;
  assign out_o.reuse_count    = o_uses_q;
  assign out_o.stored_next_pc = o_npc_q;
  assign out_o.evicted        = o_evicted_q;
  assign out_o.evicted_pc     = o_epc_q;

endmodule
`default_nettype wire

/* rtl/mtl_cell.sv */
`default_nettype none
module mtl_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire mtl_pkg::entry_t            prev_i,
  input  wire mtl_pkg::cell_ctl_t         ctl_i,
  input  wire logic [31:0]                key_pc_i,
  input  wire logic [mtl_pkg::IDX_W-1:0]  key_slot_i,
  output mtl_pkg::entry_t                 entry_o,
  output logic                            match_o,
  output logic                            slot_hit_o
);

  mtl_pkg::entry_t entry_q, entry_d;
  logic            match_q, slot_hit_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = prev_i;
    end else if (ctl_i.cur_clr) begin
      entry_d.cur = ctl_i.cur_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q    <= '0;
      match_q    <= 1'b0;
      slot_hit_q <= 1'b0;
    end else begin
      entry_q    <= entry_d;
      match_q    <= entry_q.valid && (entry_q.pc == key_pc_i);
      slot_hit_q <= entry_q.valid && (entry_q.slot == key_slot_i);
    end
  end

  assign entry_o    = entry_q;
  assign match_o    = match_q;
  assign slot_hit_o = slot_hit_q;

endmodule
`default_nettype wire
